FILE: src/aes192_cfb128_cipher_unit_defines.svh
// assertion macros shared by the aes192 cfb128 checker
`ifndef AES192_CFB128_CIPHER_UNIT_DEFINES_SVH
`define AES192_CFB128_CIPHER_UNIT_DEFINES_SVH

// condition in one cycle implies consequence in the next
`define ACFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition in one cycle implies the signal keeps its value in the next
`define ACFB_ASSERT_HOLD(label, clk, rst, ante, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: src/acfb_pkg.sv
// types, constants and round functions for the aes192 cfb128 unit
package acfb_pkg;

  localparam int KEY_WORDS  = 52;
  localparam int NUM_ROUNDS = 12;
  localparam int RK_DEPTH   = 13;
  localparam int RK_AW      = 4;
  localparam int WIDX_W     = 6;

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_IV0  = 3'd3;
  localparam logic [2:0] CFG_IV1  = 3'd4;
  localparam logic [2:0] CFG_DIR  = 3'd5;

  typedef struct packed {
    logic                exp_en;
    logic [WIDX_W-1:0]   exp_idx;
    logic                load;
    logic                rnd_en;
    logic                rnd_first;
    logic                rnd_last;
    logic [RK_AW-1:0]    rk_raddr;
    logic                finish;
  } cmd_t;

  typedef struct packed {
    logic key_wr;
  } status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = SBOX[w[8*i +: 8]];
    end
    return r;
  endfunction

  // subbytes, shiftrows and, except in the last round, mixcolumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      b[i] = SBOX[s[8*i +: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = b[i + 4*((c + i) & 3)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      if (last) begin
        r[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        r[32*c      +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        r[32*c + 8  +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        r[32*c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        r[32*c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/acfb_if.sv
// stream and configuration channel interfaces
interface acfb_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_lo;
  logic [63:0] data_hi;
  logic        restart;
  modport source (output valid, output data_lo, output data_hi, output restart, input ready);
  modport sink   (input valid, input data_lo, input data_hi, input restart, output ready);
endinterface

interface acfb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_lo;
  logic [63:0] result_hi;
  modport source (output valid, output result_lo, output result_hi, input ready);
  modport sink   (input valid, input result_lo, input result_hi, output ready);
endinterface

interface acfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/acfb_ram.sv
// generic single write port ram with registered read
module acfb_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/acfb_ctrl.sv
// sequencer for key expansion, rounds and result handoff
module acfb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  acfb_pkg::status_t status,
  output acfb_pkg::cmd_t   cmd
);
  typedef enum logic [1:0] {ST_EXPAND, ST_IDLE, ST_ROUND, ST_FINISH} state_t;

  state_t                         state;
  logic [acfb_pkg::WIDX_W-1:0]    widx;
  logic [acfb_pkg::RK_AW-1:0]     rnd;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_EXPAND: begin
        cmd.exp_en  = 1'b1;
        cmd.exp_idx = widx;
      end
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_ROUND: begin
        cmd.rnd_en    = 1'b1;
        cmd.rnd_first = (rnd == '0);
        cmd.rnd_last  = (rnd == acfb_pkg::RK_AW'(acfb_pkg::NUM_ROUNDS));
        // after the last round point back at round key zero for the next block
        cmd.rk_raddr  = cmd.rnd_last ? '0 : rnd + acfb_pkg::RK_AW'(1);
      end
      ST_FINISH: begin
        cmd.finish = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EXPAND;
      widx      <= '0;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_EXPAND: begin
          widx <= widx + acfb_pkg::WIDX_W'(1);
          if (widx == acfb_pkg::WIDX_W'(acfb_pkg::KEY_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            rnd   <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + acfb_pkg::RK_AW'(1);
          if (cmd.rnd_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.finish) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // a key write restarts the schedule
      if (status.key_wr) begin
        widx  <= '0;
        state <= ST_EXPAND;
      end
    end
  end
endmodule

FILE: src/acfb_datapath.sv
// config registers, key schedule, round unit and chaining registers
module acfb_datapath (
  input  logic               clk,
  input  logic               rst,
  input  acfb_pkg::cmd_t     cmd,
  output acfb_pkg::status_t  status,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic [63:0]        data_lo,
  input  logic [63:0]        data_hi,
  input  logic               restart,
  output logic [63:0]        result_lo,
  output logic [63:0]        result_hi
);
  logic [63:0]  key0, key1, key2, iv0, iv1;
  logic         dir;
  logic [191:0] key_all;
  logic [31:0]  win [6];
  logic [95:0]  acc;
  logic [7:0]   rcon;
  logic [2:0]   phase;
  logic [2:0]   phase_cur;
  logic [31:0]  temp;
  logic [31:0]  word;
  logic [127:0] st, din, chain, res;
  logic [127:0] rk;
  logic         rk_we;

  assign key_all = {key2, key1, key0};
  assign status.key_wr = cfg_valid &&
    (cfg_index == acfb_pkg::CFG_KEY0 || cfg_index == acfb_pkg::CFG_KEY1 ||
     cfg_index == acfb_pkg::CFG_KEY2);

  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0;
      key1 <= '0;
      key2 <= '0;
      iv0  <= '0;
      iv1  <= '0;
      dir  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        acfb_pkg::CFG_KEY0: key0 <= cfg_data;
        acfb_pkg::CFG_KEY1: key1 <= cfg_data;
        acfb_pkg::CFG_KEY2: key2 <= cfg_data;
        acfb_pkg::CFG_IV0:  iv0  <= cfg_data;
        acfb_pkg::CFG_IV1:  iv1  <= cfg_data;
        acfb_pkg::CFG_DIR:  dir  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // one schedule word per cycle; win holds the previous six words
  assign phase_cur = (cmd.exp_idx == '0) ? 3'd0 : phase;

  always_comb begin
    temp = win[5];
    if (phase_cur == 3'd0) begin
      temp = acfb_pkg::sub_word({win[5][7:0], win[5][31:8]}) ^ {24'h0, rcon};
    end
    if (cmd.exp_idx < acfb_pkg::WIDX_W'(6)) begin
      word = key_all[{cmd.exp_idx[2:0], 5'b0} +: 32];
    end else begin
      word = win[0] ^ temp;
    end
  end

  assign rk_we = cmd.exp_en && (cmd.exp_idx[1:0] == 2'd3);

  always_ff @(posedge clk) begin
    if (cmd.exp_en) begin
      for (int i = 0; i < 5; i++) begin
        win[i] <= win[i+1];
      end
      win[5] <= word;
      acc    <= {word, acc[95:32]};
      phase  <= (phase_cur == 3'd5) ? 3'd0 : phase_cur + 3'd1;
      if (cmd.exp_idx == '0) begin
        rcon <= 8'h01;
      end else if (phase_cur == 3'd0 && cmd.exp_idx >= acfb_pkg::WIDX_W'(6)) begin
        rcon <= {rcon[6:0], 1'b0};
      end
    end
  end

  acfb_ram #(
    .WIDTH(128),
    .DEPTH(acfb_pkg::RK_DEPTH)
  ) u_rk_ram (
    .clk  (clk),
    .we   (rk_we),
    .waddr(cmd.exp_idx[5:2]),
    .wdata({word, acc}),
    .raddr(cmd.rk_raddr),
    .rdata(rk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else begin
      if (cmd.load && restart) begin
        chain <= {iv1, iv0};
      end
      if (cmd.finish) begin
        chain <= dir ? din : (din ^ st);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      din <= {data_hi, data_lo};
    end
    if (cmd.rnd_en) begin
      st <= (cmd.rnd_first ? chain : acfb_pkg::aes_round(st, cmd.rnd_last)) ^ rk;
    end
    if (cmd.finish) begin
      res <= din ^ st;
    end
  end

  assign result_lo = res[63:0];
  assign result_hi = res[127:64];
endmodule

FILE: src/aes192_cfb128_cipher_unit.sv
// AES-192 CFB128 unit: after reset and after every key write the 52-word key
// schedule is rebuilt one word per cycle (no block is taken meanwhile).
// A block then goes from transfer in to result through a load step, the
// single round unit (one round key read per cycle from the round key memory)
// and a finish step that forms the result and the next chaining value once
// the output register is free. One block is in work at a time; a finished
// result waits in its output register while the next block is taken.
module aes192_cfb128_cipher_unit (
  input logic        clk,
  input logic        rst,
  acfb_in_if.sink    data_in,
  acfb_out_if.source data_out,
  acfb_cfg_if.sink   cfg
);
  acfb_pkg::cmd_t    cmd;
  acfb_pkg::status_t status;

  assign cfg.ready = 1'b1;

  acfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data_in.valid),
    .in_ready (data_in.ready),
    .out_valid(data_out.valid),
    .out_ready(data_out.ready),
    .status   (status),
    .cmd      (cmd)
  );

  acfb_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg_valid(cfg.valid),
    .cfg_index(cfg.index),
    .cfg_data (cfg.data),
    .data_lo  (data_in.data_lo),
    .data_hi  (data_in.data_hi),
    .restart  (data_in.restart),
    .result_lo(data_out.result_lo),
    .result_hi(data_out.result_hi)
  );
endmodule

FILE: src/acfb_checker.sv
// port level checks for the aes192 cfb128 unit
`include "aes192_cfb128_cipher_unit_defines.svh"

module acfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_lo,
  input logic [63:0] result_hi,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index
);
  logic in_xfer;
  logic key_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign key_xfer = cfg_valid && cfg_ready &&
    (cfg_index == acfb_pkg::CFG_KEY0 || cfg_index == acfb_pkg::CFG_KEY1 ||
     cfg_index == acfb_pkg::CFG_KEY2);

  `ACFB_ASSERT_NEXT(a_one_block, clk, rst, in_xfer, !in_ready, "input taken while busy")
  `ACFB_ASSERT_NEXT(a_no_fast_result, clk, rst, in_xfer, !$rose(out_valid), "result too early")
  `ACFB_ASSERT_NEXT(a_key_expands, clk, rst, key_xfer, !in_ready, "input open during key schedule")
  `ACFB_ASSERT_HOLD(a_result_held, clk, rst, out_valid && !out_ready, {out_valid, result_hi, result_lo}, "stalled result changed")
endmodule

bind aes192_cfb128_cipher_unit acfb_checker u_acfb_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (data_in.valid),
  .in_ready (data_in.ready),
  .out_valid(data_out.valid),
  .out_ready(data_out.ready),
  .result_lo(data_out.result_lo),
  .result_hi(data_out.result_hi),
  .cfg_valid(cfg.valid),
  .cfg_ready(cfg.ready),
  .cfg_index(cfg.index)
);
